// ----- rtl/core/hcl_pkg.sv -----
// ----------------------------------------------------------------------------
// hcl_pkg
// Shared types, register indexes and the light colour schedule for the
// home climate and light controller.
// ----------------------------------------------------------------------------
package hcl_pkg;

  localparam int TempW   = 16;
  localparam int HourW   = 5;
  localparam int SwW     = 7;
  localparam int ColourW = 13;
  localparam int CfgIdxW = 3;

  // Switch bit positions
  localparam int SwMain     = 0;
  localparam int SwSockets  = 1;
  localparam int SwLightIn  = 2;
  localparam int SwLightOut = 3;
  localparam int SwHeatIn   = 4;
  localparam int SwHeatPipe = 5;
  localparam int SwCooler   = 6;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PIPE_ON    = 3'd0,
    REG_PIPE_OFF   = 3'd1,
    REG_ROOM_ON    = 3'd2,
    REG_ROOM_OFF   = 3'd3,
    REG_COOL_ON    = 3'd4,
    REG_COOL_OFF   = 3'd5,
    REG_YARD_START = 3'd6,
    REG_YARD_END   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [TempW-1:0] pipe_heat_on_temp;
    logic [TempW-1:0] pipe_heat_off_temp;
    logic [TempW-1:0] room_heat_on_temp;
    logic [TempW-1:0] room_heat_off_temp;
    logic [TempW-1:0] cooler_on_temp;
    logic [TempW-1:0] cooler_off_temp;
    logic [HourW-1:0] yard_light_start_hour;
    logic [HourW-1:0] yard_light_end_hour;
  } cfg_regs_t;

  typedef struct packed {
    logic [TempW-1:0] outside_temp;
    logic [TempW-1:0] inside_temp;
    logic             outside_motion;
    logic             inside_motion;
    logic [HourW-1:0] hour_of_day;
  } sample_t;

  typedef struct packed {
    logic [SwW-1:0]     switch_bits;
    logic [SwW-1:0]     changed_bits;
    logic [ColourW-1:0] light_colour;
    logic               colour_changed;
  } result_t;

  localparam logic [ColourW-1:0] ColourDay   = 13'd5000;
  localparam logic [ColourW-1:0] ColourNight = 13'd2700;

  // Colour by hour: day up to 16, night from 20, -575 K per hour between.
  function automatic logic [ColourW-1:0] colour_for_hour(input logic [HourW-1:0] hour);
    logic [ColourW-1:0] c;
    begin
      case (hour)
        5'd17:   c = 13'd4425;
        5'd18:   c = 13'd3850;
        5'd19:   c = 13'd3275;
        default: c = (hour >= 5'd20) ? ColourNight : ColourDay;
      endcase
      return c;
    end
  endfunction

endpackage

// ----- rtl/core/home_climate_light_controller_top.sv -----
// ----------------------------------------------------------------------------
// home_climate_light_controller_top
// Hourly climate and light controller: seven switch bits and an inside
// light colour temperature, updated once per sample request.
// ----------------------------------------------------------------------------
// Each accepted request (two temperatures in signed hundredths of a degree,
// two motion flags and the hour) updates the switch state and the light
// colour in the same clock edge and yields exactly one result: the new
// switch bits, a mask of switches that toggled, the stored colour and a
// colour-changed flag. A request can be taken every cycle while in_stall is
// low; the state feedback is a single compare-and-select level from the
// switch and colour registers back into themselves. Results leave through a
// two-entry buffer, so in_stall rises only when both a stalled result and
// a parked one are held. Configuration writes are always taken (cfg_ready
// is high) and must happen only while the block is idle; hour registers
// keep the low five bits of cfg_data.
module home_climate_light_controller_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // sample requests
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [hcl_pkg::TempW-1:0]        in_outside_temp,
  input  logic [hcl_pkg::TempW-1:0]        in_inside_temp,
  input  logic                             in_outside_motion,
  input  logic                             in_inside_motion,
  input  logic [hcl_pkg::HourW-1:0]        in_hour_of_day,
  // results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [hcl_pkg::SwW-1:0]          out_switch_bits,
  output logic [hcl_pkg::SwW-1:0]          out_changed_bits,
  output logic [hcl_pkg::ColourW-1:0]      out_light_colour,
  output logic                             out_colour_changed,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hcl_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [hcl_pkg::TempW-1:0]        cfg_data
);

  hcl_pkg::cfg_regs_t cfg_r, cfg_nxt;
  hcl_pkg::sample_t   smp;
  hcl_pkg::result_t   step_res, buf_res;
  logic [hcl_pkg::SwW-1:0]     switch_r, switch_nxt;
  logic [hcl_pkg::ColourW-1:0] colour_r, colour_nxt;
  logic in_accept, buf_full;

  assign cfg_ready = 1'b1;

  // Register file: decode the index and update one register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (hcl_pkg::cfg_idx_t'(cfg_index))
        hcl_pkg::REG_PIPE_ON:    cfg_nxt.pipe_heat_on_temp  = cfg_data;
        hcl_pkg::REG_PIPE_OFF:   cfg_nxt.pipe_heat_off_temp = cfg_data;
        hcl_pkg::REG_ROOM_ON:    cfg_nxt.room_heat_on_temp  = cfg_data;
        hcl_pkg::REG_ROOM_OFF:   cfg_nxt.room_heat_off_temp = cfg_data;
        hcl_pkg::REG_COOL_ON:    cfg_nxt.cooler_on_temp     = cfg_data;
        hcl_pkg::REG_COOL_OFF:   cfg_nxt.cooler_off_temp    = cfg_data;
        hcl_pkg::REG_YARD_START:
          cfg_nxt.yard_light_start_hour = cfg_data[hcl_pkg::HourW-1:0];
        hcl_pkg::REG_YARD_END:
          cfg_nxt.yard_light_end_hour   = cfg_data[hcl_pkg::HourW-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pipe_heat_on_temp     <= 16'd0;
      cfg_r.pipe_heat_off_temp    <= 16'd500;
      cfg_r.room_heat_on_temp     <= 16'd2200;
      cfg_r.room_heat_off_temp    <= 16'd2500;
      cfg_r.cooler_on_temp        <= 16'd3000;
      cfg_r.cooler_off_temp       <= 16'd2500;
      cfg_r.yard_light_start_hour <= 5'd16;
      cfg_r.yard_light_end_hour   <= 5'd5;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Take a request whenever the result buffer has a free slot.
  assign in_stall  = buf_full;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    smp.outside_temp   = in_outside_temp;
    smp.inside_temp    = in_inside_temp;
    smp.outside_motion = in_outside_motion;
    smp.inside_motion  = in_inside_motion;
    smp.hour_of_day    = in_hour_of_day;
  end

  hcl_step u_step (
    .cfg        (cfg_r),
    .smp        (smp),
    .switch_cur (switch_r),
    .colour_cur (colour_r),
    .switch_nxt (switch_nxt),
    .colour_nxt (colour_nxt),
    .res        (step_res)
  );

  // Advance the switch and colour state on each accepted request; hold otherwise.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      switch_r <= '0;
      colour_r <= '0;
    end else if (in_accept) begin
      switch_r <= switch_nxt;
      colour_r <= colour_nxt;
    end
  end

  hcl_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (step_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (buf_res)
  );

  assign out_switch_bits    = buf_res.switch_bits;
  assign out_changed_bits   = buf_res.changed_bits;
  assign out_light_colour   = buf_res.light_colour;
  assign out_colour_changed = buf_res.colour_changed;

endmodule

// ----- rtl/core/hcl_step.sv -----
// ----------------------------------------------------------------------------
// hcl_step
// Next switch and colour state for one hourly sample: threshold compares
// with hysteresis, light rules and main power latch.
// ----------------------------------------------------------------------------
module hcl_step (
  input  hcl_pkg::cfg_regs_t              cfg,
  input  hcl_pkg::sample_t                smp,
  input  logic [hcl_pkg::SwW-1:0]         switch_cur,
  input  logic [hcl_pkg::ColourW-1:0]     colour_cur,
  output logic [hcl_pkg::SwW-1:0]         switch_nxt,
  output logic [hcl_pkg::ColourW-1:0]     colour_nxt,
  output hcl_pkg::result_t                res
);

  // 17-bit signed views so threshold +/- 1 cannot wrap
  logic signed [hcl_pkg::TempW:0] t_out, t_in;
  logic signed [hcl_pkg::TempW:0] pipe_on_m1, pipe_off_p1;
  logic signed [hcl_pkg::TempW:0] room_on_m1, room_off_m1;
  logic signed [hcl_pkg::TempW:0] cool_on_m1, cool_off_p1;
  logic want_pipe, want_room, want_cool, want_yard;
  logic [hcl_pkg::ColourW-1:0] colour_sched;
  logic colour_upd;
  logic [hcl_pkg::SwW-1:0] sw;

  always_comb begin
    t_out       = $signed({smp.outside_temp[hcl_pkg::TempW-1], smp.outside_temp});
    t_in        = $signed({smp.inside_temp[hcl_pkg::TempW-1], smp.inside_temp});
    pipe_on_m1  = $signed({cfg.pipe_heat_on_temp[hcl_pkg::TempW-1], cfg.pipe_heat_on_temp})
                  - 17'sd1;
    pipe_off_p1 = $signed({cfg.pipe_heat_off_temp[hcl_pkg::TempW-1], cfg.pipe_heat_off_temp})
                  + 17'sd1;
    room_on_m1  = $signed({cfg.room_heat_on_temp[hcl_pkg::TempW-1], cfg.room_heat_on_temp})
                  - 17'sd1;
    room_off_m1 = $signed({cfg.room_heat_off_temp[hcl_pkg::TempW-1], cfg.room_heat_off_temp})
                  - 17'sd1;
    cool_on_m1  = $signed({cfg.cooler_on_temp[hcl_pkg::TempW-1], cfg.cooler_on_temp})
                  - 17'sd1;
    cool_off_p1 = $signed({cfg.cooler_off_temp[hcl_pkg::TempW-1], cfg.cooler_off_temp})
                  + 17'sd1;

    want_pipe = (t_out < pipe_on_m1) ||
                (switch_cur[hcl_pkg::SwHeatPipe] && (t_out <= pipe_off_p1));
    want_room = (t_in < room_on_m1) ||
                (switch_cur[hcl_pkg::SwHeatIn] && (t_in < room_off_m1));
    want_cool = (t_in >= cool_on_m1) ||
                (switch_cur[hcl_pkg::SwCooler] && (t_in > cool_off_p1));
    want_yard = smp.outside_motion &&
                ((cfg.yard_light_end_hour > smp.hour_of_day) ||
                 (cfg.yard_light_start_hour <= smp.hour_of_day));

    sw = switch_cur;
    sw[hcl_pkg::SwHeatPipe] = want_pipe;
    sw[hcl_pkg::SwHeatIn]   = want_room;
    sw[hcl_pkg::SwCooler]   = want_cool;
    sw[hcl_pkg::SwLightOut] = want_yard;
    sw[hcl_pkg::SwLightIn]  = smp.inside_motion;
    // latch main power once anything else runs
    if (|sw[hcl_pkg::SwW-1:1]) begin
      sw[hcl_pkg::SwMain] = 1'b1;
    end

    colour_sched = hcl_pkg::colour_for_hour(smp.hour_of_day);
    colour_upd   = smp.inside_motion && (colour_sched != colour_cur);
    colour_nxt   = colour_upd ? colour_sched : colour_cur;
    switch_nxt   = sw;

    res.switch_bits    = sw;
    res.changed_bits   = sw ^ switch_cur;
    res.light_colour   = colour_nxt;
    res.colour_changed = colour_upd;
  end

endmodule

// ----- rtl/core/hcl_out_buf.sv -----
// ----------------------------------------------------------------------------
// hcl_out_buf
// Two-entry result buffer: output register plus skid register, so a new
// request is taken while a finished result waits.
// ----------------------------------------------------------------------------
module hcl_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hcl_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output hcl_pkg::result_t out_data
);

  hcl_pkg::result_t main_r, main_nxt, skid_r, skid_nxt;
  logic main_valid_r, main_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic pop;

  always_comb begin
    pop            = main_valid_r && !out_stall;
    main_nxt       = main_r;
    main_valid_nxt = main_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!main_valid_r || pop) begin
      // refill head, oldest first
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = push;
      end
    end else if (push) begin
      // head stalled: park the new result
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule
